FILE: sv/dpbd_pkg.sv
// Package for the decremental pacing block detector.
// Register map, reset values, beat layouts and the config struct; no dependencies.
`default_nettype none
package dpbd_pkg;

	localparam int TIME_BITS_DEF = 32;

	localparam int REG_W    = 32;
	localparam int VOLT_W   = 16;
	localparam int LEN_W    = 16;
	localparam int STIME_W  = 32;
	localparam int ADDR_W   = 5;
	localparam int IDX_W    = 3;

	localparam int IN_TDATA_W  = 80;
	localparam int OUT_TDATA_W = 40;
	localparam int OUT_USED_W  = 35;

	// send tolerance is step_length / TOL_SCALE
	localparam int TOL_SCALE = 100;
	localparam int TOL_LIMIT = 655;
	localparam int DIST_W    = 10;
	localparam int PROD_W    = 17;

	localparam logic [IDX_W-1:0] REG_START_PERIOD = 3'd0;
	localparam logic [IDX_W-1:0] REG_FAST_DEC     = 3'd1;
	localparam logic [IDX_W-1:0] REG_SWITCH       = 3'd2;
	localparam logic [IDX_W-1:0] REG_SLOW_DEC     = 3'd3;
	localparam logic [IDX_W-1:0] REG_THRESH       = 3'd4;
	localparam logic [IDX_W-1:0] REG_START_TIME   = 3'd5;

	localparam logic [REG_W-1:0]         RST_START_PERIOD = 32'd1000;
	localparam logic [REG_W-1:0]         RST_FAST_DEC     = 32'd50;
	localparam logic [REG_W-1:0]         RST_SWITCH       = 32'd500;
	localparam logic [REG_W-1:0]         RST_SLOW_DEC     = 32'd10;
	localparam logic signed [VOLT_W-1:0] RST_THRESH       = 16'sd0;
	localparam logic [REG_W-1:0]         RST_START_TIME   = 32'd0;

	typedef struct packed {
		logic [REG_W-1:0]         start_period;
		logic [REG_W-1:0]         fast_decrement;
		logic [REG_W-1:0]         switch_period;
		logic [REG_W-1:0]         slow_decrement;
		logic signed [VOLT_W-1:0] crossing_threshold;
		logic [REG_W-1:0]         start_time;
		logic                     load_period;
		logic                     load_send_time;
	} cfg_t;

endpackage
`default_nettype wire

FILE: sv/decremental_pacing_block_detector.sv
// Pacing timer with a shrinking period. Every input beat is one simulation step and
// yields exactly one output beat via the input then output register; a new beat is
// accepted every cycle unless the output stalls, the only loop being the timer
// state updated at the same edge that loads the output register. The send test,
// growth test and period decrement are compares, adds, subtractions and a multiply.
// Writing start_period reloads the running period; writing start_time reloads the
// last send time. Configure only while no step is in flight.
`default_nettype none
module decremental_pacing_block_detector #(
	parameter int TIME_BITS = dpbd_pkg::TIME_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [dpbd_pkg::ADDR_W-1:0]          paddr,
	input  wire logic [dpbd_pkg::REG_W-1:0]           pwdata,
	output logic      [dpbd_pkg::REG_W-1:0]           prdata,
	output logic                                      pready,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// prev_voltage, voltage, step_time, step_length
	input  wire logic [dpbd_pkg::IN_TDATA_W-1:0]      s_tdata,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// stimulate, stop, crossed, period, zero pad
	output logic      [dpbd_pkg::OUT_TDATA_W-1:0]     m_tdata
);

	dpbd_pkg::cfg_t cfg;

	logic                               valid_s1, out_free, advance;
	logic signed [dpbd_pkg::VOLT_W-1:0] prev_voltage_s1, voltage_s1;
	logic [dpbd_pkg::STIME_W-1:0]       step_time_s1;
	logic [dpbd_pkg::LEN_W-1:0]         step_length_s1;
	logic                               stimulate, stop, crossed;
	logic [dpbd_pkg::REG_W-1:0]         period;
	logic                               out_valid_q;
	logic [dpbd_pkg::OUT_USED_W-1:0]    out_data_q;

	dpbd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			prev_voltage_s1 <= s_tdata[15:0];
			voltage_s1      <= s_tdata[31:16];
			step_time_s1    <= s_tdata[63:32];
			step_length_s1  <= s_tdata[79:64];
		end
	end

	dpbd_core #(
		.TIME_BITS (TIME_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.load_value   (pwdata),
		.fire         (advance),
		.prev_voltage (prev_voltage_s1),
		.voltage      (voltage_s1),
		.step_time    (step_time_s1),
		.step_length  (step_length_s1),
		.stimulate    (stimulate),
		.stop         (stop),
		.crossed      (crossed),
		.period       (period)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {period, crossed, stop, stimulate};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = dpbd_pkg::OUT_TDATA_W'(out_data_q);

endmodule
`default_nettype wire

FILE: sv/dpbd_regs.sv
// Configuration register file with APB-style access.
// Uses dpbd_pkg for the register map and cfg_t.
`default_nettype none
module dpbd_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [dpbd_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [dpbd_pkg::REG_W-1:0]   pwdata,
	output logic      [dpbd_pkg::REG_W-1:0]   prdata,
	output logic                              pready,
	output dpbd_pkg::cfg_t                    cfg
);

	logic [dpbd_pkg::REG_W-1:0]         start_period_q, fast_dec_q, switch_q, slow_dec_q;
	logic [dpbd_pkg::REG_W-1:0]         start_time_q;
	logic signed [dpbd_pkg::VOLT_W-1:0] thresh_q;
	logic [dpbd_pkg::IDX_W-1:0]         idx;
	logic                               wr;

	assign pready = 1'b1;
	assign idx    = paddr[dpbd_pkg::ADDR_W-1:2];
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_period_q <= dpbd_pkg::RST_START_PERIOD;
			fast_dec_q     <= dpbd_pkg::RST_FAST_DEC;
			switch_q       <= dpbd_pkg::RST_SWITCH;
			slow_dec_q     <= dpbd_pkg::RST_SLOW_DEC;
			thresh_q       <= dpbd_pkg::RST_THRESH;
			start_time_q   <= dpbd_pkg::RST_START_TIME;
		end else if (wr) begin
			case (idx)
				dpbd_pkg::REG_START_PERIOD: start_period_q <= pwdata;
				dpbd_pkg::REG_FAST_DEC:     fast_dec_q     <= pwdata;
				dpbd_pkg::REG_SWITCH:       switch_q       <= pwdata;
				dpbd_pkg::REG_SLOW_DEC:     slow_dec_q     <= pwdata;
				dpbd_pkg::REG_THRESH:       thresh_q       <= pwdata[dpbd_pkg::VOLT_W-1:0];
				dpbd_pkg::REG_START_TIME:   start_time_q   <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			dpbd_pkg::REG_START_PERIOD: prdata = start_period_q;
			dpbd_pkg::REG_FAST_DEC:     prdata = fast_dec_q;
			dpbd_pkg::REG_SWITCH:       prdata = switch_q;
			dpbd_pkg::REG_SLOW_DEC:     prdata = slow_dec_q;
			dpbd_pkg::REG_THRESH:       prdata = dpbd_pkg::REG_W'(thresh_q);
			dpbd_pkg::REG_START_TIME:   prdata = start_time_q;
			default:                    prdata = '0;
		endcase
	end

	always_comb begin
		cfg.start_period       = start_period_q;
		cfg.fast_decrement     = fast_dec_q;
		cfg.switch_period      = switch_q;
		cfg.slow_decrement     = slow_dec_q;
		cfg.crossing_threshold = thresh_q;
		cfg.start_time         = start_time_q;
		// new register value rides on pwdata in the write cycle
		cfg.load_period        = wr && (idx == dpbd_pkg::REG_START_PERIOD);
		cfg.load_send_time     = wr && (idx == dpbd_pkg::REG_START_TIME);
	end

endmodule
`default_nettype wire

FILE: sv/dpbd_core.sv
// Per-step pacing logic and timer state: crossing detect, growth stop, send decision.
// Uses dpbd_pkg; driven from the input register of the top level.
`default_nettype none
module dpbd_core #(
	parameter int TIME_BITS = dpbd_pkg::TIME_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire dpbd_pkg::cfg_t                      cfg,
	input  wire logic [dpbd_pkg::REG_W-1:0]          load_value,
	input  wire logic                                fire,
	input  wire logic signed [dpbd_pkg::VOLT_W-1:0]  prev_voltage,
	input  wire logic signed [dpbd_pkg::VOLT_W-1:0]  voltage,
	input  wire logic [dpbd_pkg::STIME_W-1:0]        step_time,
	input  wire logic [dpbd_pkg::LEN_W-1:0]          step_length,
	output logic                                     stimulate,
	output logic                                     stop,
	output logic                                     crossed,
	output logic [dpbd_pkg::REG_W-1:0]               period
);

	localparam int SUM_W = ((TIME_BITS > dpbd_pkg::REG_W) ? TIME_BITS : dpbd_pkg::REG_W) + 1;

	logic [TIME_BITS-1:0]       last_send_q, recv_new_q, recv_mid_q, t;
	logic [dpbd_pkg::REG_W-1:0] period_q, dec, period_next;
	logic [1:0]                 count_q;
	logic [TIME_BITS-1:0]       ivl_new, ivl_old, ivl_diff;
	logic                       grew;
	logic [SUM_W-1:0]           due_at, t_ext, gap;
	logic [dpbd_pkg::PROD_W-1:0] tol_prod;
	logic                       due;

	assign t = TIME_BITS'(step_time);

	assign crossed = (prev_voltage < cfg.crossing_threshold)
		&& (voltage >= cfg.crossing_threshold);

	assign ivl_new  = t - recv_new_q;
	assign ivl_old  = recv_new_q - recv_mid_q;
	assign ivl_diff = ivl_new - ivl_old;
	assign grew     = (ivl_new > ivl_old) && (ivl_diff > (ivl_old >> 1));
	assign stop     = crossed && count_q[1] && grew;

	// 100*t + len > 100*(last_send + period), exact
	assign due_at   = SUM_W'(last_send_q) + SUM_W'(period_q);
	assign t_ext    = SUM_W'(t);
	assign gap      = due_at - t_ext;
	assign tol_prod = dpbd_pkg::PROD_W'(gap[dpbd_pkg::DIST_W-1:0])
		* dpbd_pkg::PROD_W'(dpbd_pkg::TOL_SCALE);
	assign due = (t_ext > due_at)
		|| ((gap <= SUM_W'(dpbd_pkg::TOL_LIMIT))
			&& (dpbd_pkg::PROD_W'(step_length) > tol_prod));

	assign stimulate   = !stop && due;
	assign dec         = (period_q > cfg.switch_period) ? cfg.fast_decrement
		: cfg.slow_decrement;
	assign period_next = (period_q > dec) ? (period_q - dec) : '0;
	assign period      = stimulate ? period_next : period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_send_q <= TIME_BITS'(dpbd_pkg::RST_START_TIME);
			period_q    <= dpbd_pkg::RST_START_PERIOD;
			count_q     <= '0;
			recv_new_q  <= '0;
			recv_mid_q  <= '0;
		end else begin
			if (cfg.load_period) begin
				period_q <= load_value;
			end else if (fire && stimulate) begin
				period_q <= period_next;
			end
			if (cfg.load_send_time) begin
				last_send_q <= TIME_BITS'(load_value);
			end else if (fire && stimulate) begin
				last_send_q <= t;
			end
			if (fire && crossed) begin
				recv_mid_q <= recv_new_q;
				recv_new_q <= t;
				if (count_q != 2'd3) begin
					count_q <= count_q + 2'd1;
				end
			end
		end
	end

endmodule
`default_nettype wire

FILE: sv/dpbd_checker.sv
// Port-level checks for the pacing block detector, bound to the top level.
// Uses only top-level ports.
`default_nettype none
module dpbd_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             m_tvalid,
	input wire logic                             m_tready,
	input wire logic [dpbd_pkg::OUT_TDATA_W-1:0] m_tdata
);

	// stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat changed while stalled");

	a_stop_no_stim: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("stimulus issued on a stop step");

	a_stop_needs_cross: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1] |-> m_tdata[2])
		else $error("stop without a crossing");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[dpbd_pkg::OUT_TDATA_W-1:dpbd_pkg::OUT_USED_W] == '0)
		else $error("output pad bits not zero");

endmodule

bind decremental_pacing_block_detector dpbd_checker u_dpbd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

FILE: sim/dpbd_pacing_monitor.sv
// Scoreboard for the decremental pacing block detector: follows register writes and
// input beats, predicts each output beat and compares it field by field.
// Depends on dpbd_pkg for register indexes, reset values and beat widths.
module dpbd_pacing_monitor (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic                             pready,
	input  logic [dpbd_pkg::ADDR_W-1:0]      paddr,
	input  logic [dpbd_pkg::REG_W-1:0]       pwdata,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic [dpbd_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [dpbd_pkg::OUT_TDATA_W-1:0] m_tdata,
	output int                               mismatches,
	output int                               outstanding
);

	typedef struct packed {
		logic                       stimulate;
		logic                       stop;
		logic                       crossed;
		logic [dpbd_pkg::REG_W-1:0] period;
	} pace_result_t;

	logic [dpbd_pkg::REG_W-1:0]         fast_dec, switch_level, slow_dec;
	logic signed [dpbd_pkg::VOLT_W-1:0] threshold;
	logic [dpbd_pkg::STIME_W-1:0]       last_send;
	logic [dpbd_pkg::REG_W-1:0]         cur_period;
	logic [1:0]                         rcv_count;
	logic [dpbd_pkg::STIME_W-1:0]       rcv_newest, rcv_middle, rcv_oldest;
	pace_result_t                       expected_beats[$];

	task automatic flag_field(input string name, input logic [dpbd_pkg::REG_W-1:0] exp_v,
			input logic [dpbd_pkg::REG_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
			mismatches++;
		end
	endtask

	task automatic check_beat(input logic [dpbd_pkg::OUT_TDATA_W-1:0] beat);
		pace_result_t exp_r;
		if (expected_beats.size() == 0) begin
			$display("%0t: unexpected beat, expected none actual %0h", $time, beat);
			mismatches++;
		end else begin
			exp_r = expected_beats.pop_front();
			flag_field("stimulate", dpbd_pkg::REG_W'(exp_r.stimulate),
				dpbd_pkg::REG_W'(beat[0]));
			flag_field("stop", dpbd_pkg::REG_W'(exp_r.stop), dpbd_pkg::REG_W'(beat[1]));
			flag_field("crossed", dpbd_pkg::REG_W'(exp_r.crossed), dpbd_pkg::REG_W'(beat[2]));
			flag_field("period", exp_r.period, beat[3 +: dpbd_pkg::REG_W]);
		end
	endtask

	task automatic write_register(input logic [dpbd_pkg::IDX_W-1:0] idx,
			input logic [dpbd_pkg::REG_W-1:0] data);
		case (idx)
			dpbd_pkg::REG_START_PERIOD: cur_period = data;
			dpbd_pkg::REG_FAST_DEC: fast_dec = data;
			dpbd_pkg::REG_SWITCH: switch_level = data;
			dpbd_pkg::REG_SLOW_DEC: slow_dec = data;
			dpbd_pkg::REG_THRESH: threshold = data[dpbd_pkg::VOLT_W-1:0];
			dpbd_pkg::REG_START_TIME: last_send = data;
			default: ;
		endcase
	endtask

	task automatic advance_timer(input logic [dpbd_pkg::IN_TDATA_W-1:0] beat);
		logic signed [dpbd_pkg::VOLT_W-1:0] pv, v;
		logic [dpbd_pkg::STIME_W-1:0]       t, newer, older;
		logic [dpbd_pkg::LEN_W-1:0]         len;
		logic [63:0]                        due_lhs, due_rhs;
		logic [dpbd_pkg::REG_W-1:0]         dec;
		pace_result_t                       r;
		pv = beat[dpbd_pkg::VOLT_W-1:0];
		v = beat[dpbd_pkg::VOLT_W +: dpbd_pkg::VOLT_W];
		t = beat[2*dpbd_pkg::VOLT_W +: dpbd_pkg::STIME_W];
		len = beat[2*dpbd_pkg::VOLT_W+dpbd_pkg::STIME_W +: dpbd_pkg::LEN_W];
		r = '0;
		r.crossed = (pv < threshold) && (v >= threshold);
		if (r.crossed) begin
			rcv_oldest = rcv_middle;
			rcv_middle = rcv_newest;
			rcv_newest = t;
			if (rcv_count != 2'd3)
				rcv_count = rcv_count + 2'd1;
			if (rcv_count == 2'd3) begin
				newer = rcv_newest - rcv_middle;
				older = rcv_middle - rcv_oldest;
				r.stop = (64'(newer) * 64'd2) > (64'(older) * 64'd3);
			end
		end
		// exact tolerance test on the unwrapped send deadline
		due_lhs = 64'(t) * 64'(dpbd_pkg::TOL_SCALE) + 64'(len);
		due_rhs = (64'(last_send) + 64'(cur_period)) * 64'(dpbd_pkg::TOL_SCALE);
		if (!r.stop && due_lhs > due_rhs) begin
			r.stimulate = 1'b1;
			last_send = t;
			dec = (cur_period > switch_level) ? fast_dec : slow_dec;
			cur_period = (cur_period > dec) ? cur_period - dec : '0;
		end
		r.period = cur_period;
		expected_beats = {expected_beats, r};
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_dec = dpbd_pkg::RST_FAST_DEC;
			switch_level = dpbd_pkg::RST_SWITCH;
			slow_dec = dpbd_pkg::RST_SLOW_DEC;
			threshold = dpbd_pkg::RST_THRESH;
			last_send = dpbd_pkg::RST_START_TIME;
			cur_period = dpbd_pkg::RST_START_PERIOD;
			rcv_count = '0;
			rcv_newest = '0;
			rcv_middle = '0;
			rcv_oldest = '0;
			expected_beats.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (m_tvalid && m_tready)
				check_beat(m_tdata);
			if (psel && penable && pwrite && pready)
				write_register(paddr[dpbd_pkg::ADDR_W-1:2], pwdata);
			if (s_tvalid && s_tready)
				advance_timer(s_tdata);
			outstanding = expected_beats.size();
		end
	end

endmodule

FILE: sim/decremental_pacing_block_detector_test.sv
// Testbench top for the decremental pacing block detector: resets, configures over APB,
// sends directed and random step beats under varied idling, and prints the verdict.
// Depends on dpbd_pkg, the block and dpbd_pacing_monitor.
module decremental_pacing_block_detector_test;

	localparam int LIMIT_CYCLES = 200000;
	localparam logic [dpbd_pkg::IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [dpbd_pkg::IDX_W-1:0] REG_SPARE_HI = 3'd7;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             psel = 1'b0;
	logic                             penable = 1'b0;
	logic                             pwrite = 1'b0;
	logic [dpbd_pkg::ADDR_W-1:0]      paddr = '0;
	logic [dpbd_pkg::REG_W-1:0]       pwdata = '0;
	logic [dpbd_pkg::REG_W-1:0]       prdata;
	logic                             pready;
	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	// prev_voltage, voltage, step_time, step_length
	logic [dpbd_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	// stimulate, stop, crossed, period, zero pad
	logic [dpbd_pkg::OUT_TDATA_W-1:0] m_tdata;
	int                               mismatches;
	int                               outstanding;

	int                                 snd_idle_pct = 0;
	int                                 rcv_stall_pct = 0;
	logic signed [dpbd_pkg::VOLT_W-1:0] cur_th = dpbd_pkg::RST_THRESH;
	logic [dpbd_pkg::STIME_W-1:0]       cur_t = '0;

	decremental_pacing_block_detector uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	dpbd_pacing_monitor pacing_mon (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= rcv_stall_pct);

	function automatic int rnd_between(input int lo, input int hi);
		return lo + int'($urandom_range(hi - lo));
	endfunction

	function automatic logic [dpbd_pkg::IN_TDATA_W-1:0] step_beat(
			input logic signed [dpbd_pkg::VOLT_W-1:0] pv,
			input logic signed [dpbd_pkg::VOLT_W-1:0] v, input logic [dpbd_pkg::STIME_W-1:0] t,
			input logic [dpbd_pkg::LEN_W-1:0] len);
		return {len, t, v, pv};
	endfunction

	task automatic push_step(input logic [dpbd_pkg::IN_TDATA_W-1:0] beat);
		while ($urandom_range(99) < snd_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= beat;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_write(input logic [dpbd_pkg::IDX_W-1:0] idx,
			input logic [dpbd_pkg::REG_W-1:0] data);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
	endtask

	task automatic load_config(input logic [dpbd_pkg::REG_W-1:0] sp,
			input logic [dpbd_pkg::REG_W-1:0] fast,
			input logic [dpbd_pkg::REG_W-1:0] sw, input logic [dpbd_pkg::REG_W-1:0] slow,
			input logic signed [dpbd_pkg::VOLT_W-1:0] th, input logic [dpbd_pkg::REG_W-1:0] st);
		reg_write(dpbd_pkg::REG_START_PERIOD, sp);
		reg_write(dpbd_pkg::REG_FAST_DEC, fast);
		reg_write(dpbd_pkg::REG_SWITCH, sw);
		reg_write(dpbd_pkg::REG_SLOW_DEC, slow);
		reg_write(dpbd_pkg::REG_THRESH, {16'($urandom), th});
		reg_write(dpbd_pkg::REG_START_TIME, st);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		cur_th = th;
	endtask

	// well-formed runs of steps with spaced crossings, mixed with raw noise beats
	task automatic run_chunk(input int n_items);
		int                                 base_gap;
		int                                 cross_in;
		logic signed [dpbd_pkg::VOLT_W-1:0] pv, v;
		logic [dpbd_pkg::LEN_W-1:0]         len;
		base_gap = $urandom_range(3, 10);
		cross_in = $urandom_range(0, 3);
		for (int n = 0; n < n_items; n++) begin
			if ($urandom_range(99) < 12) begin
				push_step(dpbd_pkg::IN_TDATA_W'({$urandom, $urandom, $urandom}));
			end else begin
				cur_t += ($urandom_range(9) == 0) ? $urandom_range(0, 2000)
					: $urandom_range(1, 30);
				len = ($urandom_range(3) == 0) ? dpbd_pkg::LEN_W'($urandom)
					: dpbd_pkg::LEN_W'($urandom_range(0, 60));
				if (cross_in == 0 && cur_th != -16'sd32768) begin
					pv = dpbd_pkg::VOLT_W'(rnd_between(-32768, int'(cur_th) - 1));
					v = dpbd_pkg::VOLT_W'(rnd_between(int'(cur_th), 32767));
					cross_in = ($urandom_range(3) == 0) ? 2 * base_gap + $urandom_range(0, 3)
						: base_gap + $urandom_range(0, 2);
				end else begin
					pv = dpbd_pkg::VOLT_W'($urandom);
					v = dpbd_pkg::VOLT_W'($urandom);
					if (pv < cur_th && v >= cur_th)
						v = pv;
					if (cross_in > 0)
						cross_in--;
				end
				push_step(step_beat(pv, v, cur_t, len));
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: extremes, exact 1.5 growth, stop, tolerance edge, fast to slow
		push_step(step_beat(16'sh8000, 16'sh7fff, 32'd0, 16'd0));
		push_step(step_beat(16'sh7fff, 16'sh8000, 32'd100, 16'hffff));
		push_step(step_beat(-16'sd1, 16'sd0, 32'd200, 16'd0));
		push_step(step_beat(16'sd0, 16'sd0, 32'd300, 16'd0));
		push_step(step_beat(-16'sd1, 16'sd1, 32'd500, 16'd0));
		push_step(step_beat(-16'sd5, 16'sd5, 32'd1000, 16'd0));
		push_step(step_beat(16'sd0, 16'sd0, 32'd995, 16'd500));
		push_step(step_beat(16'sd0, 16'sd0, 32'd995, 16'd501));
		push_step(step_beat(-16'sd1, 16'sd0, 32'd3000, 16'd0));
		push_step(step_beat(16'sd0, 16'sd0, 32'd3000, 16'd0));
		for (int k = 1; k <= 9; k++)
			push_step(step_beat(16'sd0, 16'sd0, dpbd_pkg::STIME_W'(10000 * k), 16'd0));
		push_step(step_beat(16'sd0, 16'sd0, 32'hffff_ffff, 16'hffff));
		push_step(step_beat(-16'sd1, 16'sd0, 32'd5, 16'd0));
		drain();

		reg_write(REG_SPARE_LO, $urandom);
		reg_write(REG_SPARE_HI, $urandom);
		for (int k = 0; k < 6; k++) begin
			case (k)
				2: begin
					cur_t = 32'hffff_ff00;
					load_config($urandom_range(50, 300), '1, '0, '1, 16'sh7fff, cur_t);
				end
				3: begin
					cur_t = $urandom;
					load_config('0, '0, '0, '0, 16'sh8000, '0);
				end
				4: begin
					cur_t = 32'hffff_ff00;
					load_config('1, 32'd1, '1, '1, 16'sd0, '0);
				end
				default: begin
					cur_t = $urandom;
					load_config($urandom_range(20, 600), $urandom_range(0, 60),
						$urandom_range(0, 300), $urandom_range(0, 8),
						dpbd_pkg::VOLT_W'(rnd_between(-2000, 2000)), cur_t);
				end
			endcase
			case (k)
				1: begin
					snd_idle_pct = 72;
					rcv_stall_pct = 0;
				end
				2: begin
					snd_idle_pct = 0;
					rcv_stall_pct = 72;
				end
				3, 5: begin
					snd_idle_pct = 22;
					rcv_stall_pct = 22;
				end
				default: begin
					snd_idle_pct = 0;
					rcv_stall_pct = 0;
				end
			endcase
			run_chunk((k == 4) ? 30 : ((k < 2) ? 80 : 70));
			drain();
		end

		if (mismatches == 0)
			$display("decremental_pacing_block_detector verification clean");
		else
			$display("decremental_pacing_block_detector verification failed");
		$finish;
	end

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("decremental_pacing_block_detector verification failed");
		$finish;
	end

endmodule
